// ===== rtl/core/mts_pkg.sv =====
// Shared types, constants and the note frequency table for the melody tone sequencer.
package mts_pkg;

  localparam int NOTE_W = 6;
  localparam int DUR_W  = 16;
  localparam int OUT_W  = 12;
  localparam int LOUD_W = 7;
  localparam int NUM_W  = 20;
  localparam int DEN_W  = 13;
  localparam int CNT_W  = 5;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_START  = 2'd3;

  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_LOUDNESS = 1'b1;

  localparam logic [NUM_W-1:0]  PERIOD_NUM    = 20'd1000000;
  localparam logic [LOUD_W-1:0] LOUD_MAX      = 7'd99;
  localparam logic [LOUD_W-1:0] LOUD_SPAN     = 7'd100;
  localparam logic [LOUD_W-1:0] LOUD_RESET    = 7'd20;
  localparam logic [DUR_W-1:0]  COUNT_WRAP    = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NOTE_W-1:0] note_index;
    logic [DUR_W-1:0]  duration;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] period;
    logic [OUT_W-1:0] compare;
    logic             tone_on;
    logic             busy_res;
  } result_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [DUR_W-1:0]  dur;
  } entry_t;

  function automatic logic [DEN_W-1:0] note_freq(input logic [NOTE_W-1:0] note);
    logic [DEN_W-1:0] f;
    case (note)
      6'd1:  f = 13'd262;   6'd2:  f = 13'd277;   6'd3:  f = 13'd294;
      6'd4:  f = 13'd311;   6'd5:  f = 13'd330;   6'd6:  f = 13'd349;
      6'd7:  f = 13'd370;   6'd8:  f = 13'd392;   6'd9:  f = 13'd415;
      6'd10: f = 13'd440;   6'd11: f = 13'd466;   6'd12: f = 13'd494;
      6'd13: f = 13'd523;   6'd14: f = 13'd554;   6'd15: f = 13'd587;
      6'd16: f = 13'd622;   6'd17: f = 13'd659;   6'd18: f = 13'd698;
      6'd19: f = 13'd740;   6'd20: f = 13'd784;   6'd21: f = 13'd830;
      6'd22: f = 13'd880;   6'd23: f = 13'd932;   6'd24: f = 13'd988;
      6'd25: f = 13'd1047;  6'd26: f = 13'd1109;  6'd27: f = 13'd1175;
      6'd28: f = 13'd1245;  6'd29: f = 13'd1319;  6'd30: f = 13'd1397;
      6'd31: f = 13'd1480;  6'd32: f = 13'd1568;  6'd33: f = 13'd1661;
      6'd34: f = 13'd1760;  6'd35: f = 13'd1865;  6'd36: f = 13'd1976;
      6'd37: f = 13'd2093;  6'd38: f = 13'd2218;  6'd39: f = 13'd2349;
      6'd40: f = 13'd2489;  6'd41: f = 13'd2637;  6'd42: f = 13'd2794;
      6'd43: f = 13'd2960;  6'd44: f = 13'd3136;  6'd45: f = 13'd3322;
      6'd46: f = 13'd3520;  6'd47: f = 13'd3729;  6'd48: f = 13'd3951;
      6'd49: f = 13'd4186;  6'd50: f = 13'd4435;  6'd51: f = 13'd4699;
      6'd52: f = 13'd4978;  6'd53: f = 13'd5274;  6'd54: f = 13'd5588;
      6'd55: f = 13'd5920;  6'd56: f = 13'd6272;  6'd57: f = 13'd6645;
      6'd58: f = 13'd7040;  6'd59: f = 13'd7459;  6'd60: f = 13'd7902;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/melody_tone_sequencer.sv =====
// Top level of the tick-driven buzzer melody sequencer.
//
// Items enter on the command port: an item transfers at a rising edge where start
// is high and busy is low. Commands are tick, append note, clear melody and start
// playback. Every item gives exactly one result, shown on the result port for one
// cycle with done high; the receiver cannot stall it, so it must take it then.
// The result is the state after the item: period, compare, tone on and playing.
// Append, clear, start and ticks that load no note give their result in the
// cycle after the transfer and the port is ready again in that cycle.
// A tick that loads a stored note reads the store first; a note with a
// frequency then runs the shared divider twice, for 1000000 / frequency and then
// for period / (100 - loudness), with loudness capped at 99. The port stays busy
// until such an item gives its result; a stored silent note skips the divider,
// and the terminator skips both the store read and the divider.
// The registers enable and loudness are written through the cfg port, at once.
// A synchronous reset empties the melody, stops playback, zeroes period and
// compare and sets enable to 1 and loudness to 20; store contents are kept.
module melody_tone_sequencer #(
  parameter int MELODY_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  mts_pkg::item_t             item,
  output logic                       done,
  output mts_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [mts_pkg::LOUD_W-1:0] cfg_data
);

  localparam int AW = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
  localparam int LW = $clog2(MELODY_DEPTH + 1);
  localparam int PW = $clog2(MELODY_DEPTH + 2);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_READ    = 5'b00010,
    S_LOAD    = 5'b00100,
    S_DIV_PER = 5'b01000,
    S_DIV_CMP = 5'b10000
  } state_t;

  state_t                     state;
  logic [LW-1:0]              melody_length;
  logic [PW-1:0]              play_position;
  logic [mts_pkg::DUR_W-1:0]  tick_count;
  logic                       playing;
  logic                       timer_running;
  logic [mts_pkg::OUT_W-1:0]  period_reg;
  logic [mts_pkg::OUT_W-1:0]  compare_reg;
  logic                       enable;
  logic [mts_pkg::LOUD_W-1:0] loudness;
  logic [mts_pkg::NOTE_W-1:0] cur_note;
  logic [mts_pkg::DUR_W-1:0]  cur_dur;

  logic                       accept;
  logic                       store_we;
  logic                       store_re;
  mts_pkg::entry_t            wentry;
  mts_pkg::entry_t            rentry;
  logic                       active;
  logic                       has_note;
  logic [mts_pkg::DEN_W-1:0]  freq;
  logic [mts_pkg::LOUD_W-1:0] loud_eff;
  logic [mts_pkg::LOUD_W-1:0] vol_div;
  logic                       div_start;
  logic [mts_pkg::NUM_W-1:0]  div_dividend;
  logic [mts_pkg::DEN_W-1:0]  div_divisor;
  logic                       div_done;
  logic [mts_pkg::NUM_W-1:0]  div_quotient;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign active   = playing && enable && (play_position <= PW'(melody_length));
  assign has_note = (play_position < PW'(melody_length));
  assign store_we = accept && (item.cmd == mts_pkg::CMD_APPEND)
                    && (melody_length != LW'(MELODY_DEPTH));
  assign store_re = accept && (item.cmd == mts_pkg::CMD_TICK) && active
                    && (tick_count == '0) && has_note;
  assign wentry   = '{note: item.note_index, dur: item.duration};
  assign freq     = mts_pkg::note_freq(cur_note);
  assign loud_eff = (loudness > mts_pkg::LOUD_MAX) ? mts_pkg::LOUD_MAX : loudness;
  assign vol_div  = mts_pkg::LOUD_SPAN - loud_eff;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = mts_pkg::PERIOD_NUM;
    div_divisor  = freq;
    if ((state == S_LOAD) && (freq != '0)) begin
      div_start = 1'b1;
    end else if ((state == S_DIV_PER) && div_done) begin
      div_start    = 1'b1;
      div_dividend = div_quotient;
      div_divisor  = mts_pkg::DEN_W'(vol_div);
    end
  end

  mts_store #(
    .DEPTH (MELODY_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (melody_length[AW-1:0]),
    .wdata (wentry),
    .re    (store_re),
    .raddr (play_position[AW-1:0]),
    .rdata (rentry)
  );

  mts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b1;
      loudness <= mts_pkg::LOUD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mts_pkg::REG_ENABLE:   enable   <= cfg_data[0];
        mts_pkg::REG_LOUDNESS: loudness <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      melody_length <= '0;
      play_position <= '0;
      tick_count    <= '0;
      playing       <= 1'b0;
      timer_running <= 1'b0;
      period_reg    <= '0;
      compare_reg   <= '0;
      cur_note      <= '0;
      cur_dur       <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.cmd)
              mts_pkg::CMD_APPEND: begin
                if (store_we) begin
                  melody_length <= melody_length + 1'b1;
                end
                done <= 1'b1;
              end
              mts_pkg::CMD_CLEAR: begin
                melody_length <= '0;
                done          <= 1'b1;
              end
              mts_pkg::CMD_START: begin
                play_position <= '0;
                tick_count    <= '0;
                timer_running <= 1'b0;
                playing       <= 1'b1;
                done          <= 1'b1;
              end
              default: begin
                if (!active) begin
                  timer_running <= 1'b0;
                  playing       <= 1'b0;
                  done          <= 1'b1;
                end else if (tick_count != '0) begin
                  tick_count <= tick_count - 1'b1;
                  done       <= 1'b1;
                end else begin
                  tick_count <= mts_pkg::COUNT_WRAP;
                  if (has_note) begin
                    state <= S_READ;
                  end else begin
                    cur_note <= '0;
                    cur_dur  <= '0;
                    state    <= S_LOAD;
                  end
                end
              end
            endcase
          end
        end
        S_READ: begin
          cur_note <= rentry.note;
          cur_dur  <= rentry.dur;
          state    <= S_LOAD;
        end
        S_LOAD: begin
          if (freq == '0) begin
            period_reg    <= '0;
            compare_reg   <= '0;
            tick_count    <= cur_dur;
            timer_running <= 1'b1;
            play_position <= play_position + 1'b1;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_DIV_PER;
          end
        end
        S_DIV_PER: begin
          if (div_done) begin
            period_reg <= div_quotient[mts_pkg::OUT_W-1:0];
            state      <= S_DIV_CMP;
          end
        end
        S_DIV_CMP: begin
          if (div_done) begin
            compare_reg   <= div_quotient[mts_pkg::OUT_W-1:0];
            tick_count    <= cur_dur;
            timer_running <= 1'b1;
            play_position <= play_position + 1'b1;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result = '{period:   period_reg,
                    compare:  compare_reg,
                    tone_on:  timer_running,
                    busy_res: playing};

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a note load is still running");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("transferred item produced neither a result nor a note load");

  a_compare_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.compare <= result.period))
    else $error("compare value exceeds the tone period");

  a_tone_playing: assert property (@(posedge clk) disable iff (rst)
    result.tone_on |-> result.busy_res)
    else $error("tone running while playback is stopped");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    store_re |-> (play_position < PW'(MELODY_DEPTH)))
    else $error("store read beyond its depth");

endmodule

// ===== rtl/core/mts_store.sv =====
// Melody note store: one write port and one registered read port.
module mts_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mts_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output mts_pkg::entry_t rdata
);

  mts_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mts_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module mts_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mts_pkg::NUM_W-1:0] dividend,
  input  logic [mts_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [mts_pkg::NUM_W-1:0] quotient
);

  logic                      running;
  logic [mts_pkg::CNT_W-1:0] count;
  logic [mts_pkg::DEN_W-1:0] rem;
  logic [mts_pkg::DEN_W-1:0] den;
  logic [mts_pkg::DEN_W:0]   shifted;
  logic [mts_pkg::DEN_W:0]   den_ext;
  logic [mts_pkg::DEN_W:0]   diff;
  logic                      ge;

  assign shifted = {rem, quotient[mts_pkg::NUM_W-1]};
  assign den_ext = {1'b0, den};
  assign diff    = shifted - den_ext;
  assign ge      = (shifted >= den_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      count   <= '0;
    end else if (running) begin
      count <= count + 1'b1;
      if (count == mts_pkg::CNT_W'(mts_pkg::NUM_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      rem      <= ge ? diff[mts_pkg::DEN_W-1:0] : shifted[mts_pkg::DEN_W-1:0];
      quotient <= {quotient[mts_pkg::NUM_W-2:0], ge};
    end
  end

endmodule
